FILE: rtl/core/meter_lcd_frame_decoder_core_assert.svh
// Assertion macros for the meter LCD frame decoder core
`ifndef METER_LCD_FRAME_DECODER_CORE_ASSERT_SVH
`define METER_LCD_FRAME_DECODER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define MLFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle
`define MLFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/mlfd_pkg.sv
// Shared types and constants of the meter LCD frame decoder
`timescale 1ns / 1ps
package mlfd_pkg;
  localparam logic [7:0] HdrFirst  = 8'h5A;
  localparam logic [7:0] HdrSecond = 8'hA5;
  localparam logic [7:0] SegMask   = 8'hEF;
  localparam logic [7:0] DotBit    = 8'h10;

  localparam logic [1:0] KindNum    = 2'd0;
  localparam logic [1:0] KindOpen   = 2'd1;
  localparam logic [1:0] KindText   = 2'd2;
  localparam logic [1:0] KindReject = 2'd3;

  localparam logic [3:0] UNone = 4'd0;
  localparam logic [3:0] UV    = 4'd1;
  localparam logic [3:0] UMv   = 4'd2;
  localparam logic [3:0] UOhm  = 4'd3;
  localparam logic [3:0] UKohm = 4'd4;
  localparam logic [3:0] UMohm = 4'd5;
  localparam logic [3:0] UF    = 4'd6;
  localparam logic [3:0] UNf   = 4'd7;
  localparam logic [3:0] UUf   = 4'd8;
  localparam logic [3:0] UMf   = 4'd9;
  localparam logic [3:0] UA    = 4'd10;
  localparam logic [3:0] UMa   = 4'd11;
  localparam logic [3:0] UUa   = 4'd12;
  localparam logic [3:0] UDeg  = 4'd13;

  localparam logic [3:0] ChA = 4'd10;
  localparam logic [3:0] ChU = 4'd11;
  localparam logic [3:0] ChT = 4'd12;
  localparam logic [3:0] ChO = 4'd13;
  localparam logic [3:0] ChL = 4'd14;
  localparam logic [3:0] ChE = 4'd15;

  // Measurement mode indexes
  localparam logic [3:0] ModeAuto    = 4'd0;
  localparam logic [3:0] ModeVolt    = 4'd1;
  localparam logic [3:0] ModeVoltImp = 4'd2;
  localparam logic [3:0] ModeOhm     = 4'd3;
  localparam logic [3:0] ModeOhmVolt = 4'd4;
  localparam logic [3:0] ModeCap     = 4'd5;
  localparam logic [3:0] ModeBare    = 4'd6;
  localparam logic [3:0] ModeCont    = 4'd7;
  localparam logic [3:0] ModeTemp    = 4'd8;
  localparam logic [3:0] ModeAmpHi   = 4'd9;
  localparam logic [3:0] ModeAmpHi2  = 4'd10;
  localparam logic [3:0] ModeMaLo    = 4'd11;
  localparam logic [3:0] ModeMaLo2   = 4'd12;

  localparam logic [3:0] ModeMax = 4'd12;
  localparam int QueueDepth = 2;

  // Captured frame bytes 2..8 with the mode in force
  typedef struct packed {
    logic [3:0]     mode;
    logic [6:0][7:0] body;
  } frame_t;

  // One decoded result
  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         unit_code;
    logic signed [24:0] value_milli;
    logic [2:0]         frac_places;
    logic [3:0][3:0]    chars;
  } reading_t;

  // Map a masked segment pattern to its character; bit 4 flags an unknown code
  function automatic logic [4:0] seg_decode(input logic [7:0] m);
    logic [4:0] c;
    case (m)
      8'h00, 8'hEB: c = 5'd0;
      8'h0A: c = 5'd1;
      8'hAD: c = 5'd2;
      8'h8F: c = 5'd3;
      8'h4E: c = 5'd4;
      8'hC7: c = 5'd5;
      8'hE7: c = 5'd6;
      8'h8A: c = 5'd7;
      8'hEF: c = 5'd8;
      8'hCF: c = 5'd9;
      8'hEE: c = 5'd10;
      8'h23: c = 5'd11;
      8'h65: c = 5'd12;
      8'h27: c = 5'd13;
      8'h61: c = 5'd14;
      8'hE5: c = 5'd15;
      default: c = 5'd16;
    endcase
    return c;
  endfunction
endpackage

FILE: rtl/core/meter_lcd_frame_decoder_core.sv
// Top level of the meter LCD frame decoder
//  channel  | handshake                 | payload
//  input    | in_valid / in_stall       | rx_data
//  config   | cfg_write                 | cfg_data (mode)
//  output   | out_valid / out_stall     | kind .. changed
// One byte is accepted per cycle unless stalled; a completed frame is pushed into
// a two-entry frame queue and reaches the output through a two-stage back end.
// Reset is synchronous and clears the hunt, the queue and the held reading.
// Only the last byte of a frame can stall, when the frame queue is full.
`timescale 1ns / 1ps
`include "meter_lcd_frame_decoder_core_assert.svh"
module meter_lcd_frame_decoder_core import mlfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [3:0]         unit_code,
  output logic signed [24:0] value_milli,
  output logic [2:0]         frac_places,
  output logic [3:0]         char_first,
  output logic [3:0]         char_second,
  output logic [3:0]         char_third,
  output logic [3:0]         char_fourth,
  output logic               changed
);
  logic [3:0] meter_mode;
  logic restart;
  logic fv, qfull, qv, qtake;
  frame_t fin, fout;

  // Accept only valid mode writes
  assign restart = cfg_write && (cfg_data <= ModeMax);
  always_ff @(posedge clk) begin
    if (rst) meter_mode <= 4'd0;
    else if (restart) meter_mode <= cfg_data;
  end

  mlfd_front u_front (
    .clk, .rst, .in_valid, .in_stall, .rx_data, .mode(meter_mode), .restart,
    .frame_valid(fv), .frame(fin), .frame_stall(qfull)
  );
  mlfd_queue u_queue (
    .clk, .rst, .wr_valid(fv), .full(qfull), .wr_data(fin),
    .rd_valid(qv), .rd_take(qtake), .rd_data(fout)
  );
  mlfd_back u_back (
    .clk, .rst, .restart, .frm_valid(qv), .frm_take(qtake), .frm(fout),
    .out_valid, .out_stall, .kind, .unit_code, .value_milli, .frac_places,
    .char_first, .char_second, .char_third, .char_fourth, .changed
  );

  `MLFD_ASSERT_IMP(a_no_push_full, clk, rst, qfull, !fv, "push into full queue")
  `MLFD_ASSERT_IMP(a_reject_clean, clk, rst, out_valid && kind == KindReject,
    !changed && value_milli == 25'sd0, "rejected frame carries data")
  `MLFD_ASSERT_NEXT(a_mode_range, clk, rst, 1'b1, meter_mode <= ModeMax, "mode out of range")
endmodule

FILE: rtl/core/mlfd_front.sv
// Front end: header hunt and frame capture
`timescale 1ns / 1ps
module mlfd_front import mlfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_data,
  input  logic [3:0] mode,
  input  logic       restart,
  output logic       frame_valid,
  output frame_t     frame,
  input  logic       frame_stall
);
  logic [3:0] frame_position;
  logic [6:0][7:0] body;
  logic take;

  // Stall only the last byte of a frame when the queue is full
  assign in_stall = frame_stall && (frame_position == 4'd8);
  assign take = in_valid && !in_stall;
  assign frame_valid = take && (frame_position == 4'd8);
  always_comb begin
    frame.mode = mode;
    frame.body = body;
    frame.body[6] = rx_data;
  end

  // Advance the header hunt and store frame bytes
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      frame_position <= 4'd0;
    end else if (take) begin
      case (frame_position)
        4'd0: frame_position <= (rx_data == HdrFirst) ? 4'd1 : 4'd0;
        4'd1: frame_position <= (rx_data == HdrSecond) ? 4'd2 :
                                (rx_data == HdrFirst) ? 4'd1 : 4'd0;
        4'd8: frame_position <= 4'd0;
        default: frame_position <= frame_position + 4'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame_position >= 4'd2 && frame_position <= 4'd7) begin
      body[3'(frame_position - 4'd2)] <= rx_data;
    end
  end
endmodule

FILE: rtl/core/mlfd_queue.sv
// Two-entry frame queue between front and back
`timescale 1ns / 1ps
module mlfd_queue import mlfd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   full,
  input  frame_t wr_data,
  output logic   rd_valid,
  input  logic   rd_take,
  output frame_t rd_data
);
  frame_t slot [QueueDepth];
  logic   wp, rp;
  logic [1:0] count;

  assign full = (count == 2'(QueueDepth));
  assign rd_valid = (count != 2'd0);
  assign rd_data = slot[rp];

  // Push at the write slot, pop at the read slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid) wp <= ~wp;
      if (rd_take) rp <= ~rp;
      count <= count + 2'(wr_valid) - 2'(rd_take);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) slot[wp] <= wr_data;
  end
endmodule

FILE: rtl/core/mlfd_back.sv
// Back end: segment decode, mode rules, change tracking and output register
`timescale 1ns / 1ps
module mlfd_back import mlfd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   restart,
  input  logic   frm_valid,
  output logic   frm_take,
  input  frame_t frm,
  output logic   out_valid,
  input  logic   out_stall,
  output logic [1:0]         kind,
  output logic [3:0]         unit_code,
  output logic signed [24:0] value_milli,
  output logic [2:0]         frac_places,
  output logic [3:0]         char_first,
  output logic [3:0]         char_second,
  output logic [3:0]         char_third,
  output logic [3:0]         char_fourth,
  output logic               changed
);
  // Stage 1: decode into digits, unit and scale
  logic        s1_valid;
  logic        s1_ok;
  reading_t    s1_r;
  logic [13:0] s1_n;
  logic [2:0]  s1_sc;
  logic        s1_neg;
  logic        s1_num;

  logic [3:0] md;
  logic [7:0] f2, f6, f7, f8;
  logic [2:0] p;
  logic [3:0] unit;
  logic [3:0][3:0] ch;
  logic [4:0] code;
  logic [7:0] seg;
  logic bad, has_l, zero, neg, onemin, hic, loc, isres, iscur, ok;
  logic [2:0] alpha, fp, sc, imp;
  logic [1:0] knd;
  logic [1:0] dot;
  logic dot_any;
  logic [13:0] n;
  logic s1_go, s2_go;
  logic s2_valid;

  assign md = frm.mode;
  assign f2 = frm.body[0];
  assign f6 = frm.body[4];
  assign f7 = frm.body[5];
  assign f8 = frm.body[6];
  assign hic = (md == ModeAmpHi) || (md == ModeAmpHi2);
  assign loc = (md == ModeMaLo) || (md == ModeMaLo2);

  always_comb begin
    // Unit prefix and unit flags
    if (f6[6]) p = 3'd1;
    else if (f6[5]) p = 3'd2;
    else if (f6[4]) p = 3'd3;
    else if (f7[2]) p = 3'd4;
    else if (f7[0]) p = 3'd5;
    else p = 3'd0;
    if (f7[5]) unit = (p == 3'd1) ? UKohm : (p == 3'd4) ? UMohm : UOhm;
    else if (f7[4]) begin
      if (p == 3'd2) unit = UNf;
      else if (p == 3'd3) unit = UUf;
      else if (p == 3'd4 || p == 3'd5) unit = UMf;
      else unit = UF;
    end else if (f8[1]) unit = (p == 3'd5) ? UMv : UV;
    else if (f8[0]) begin
      if (hic) unit = UA;
      else if (loc) unit = UMa;
      else if (p == 3'd5) unit = UMa;
      else if (p == 3'd3) unit = UUa;
      else unit = UA;
    end else if (f8[5]) unit = UDeg;
    else if (f8[4]) unit = UV;
    else begin
      case (md)
        ModeBare: unit = UNone;
        ModeOhm: unit = UMohm;
        ModeCont: unit = UOhm;
        ModeCap: unit = UNf;
        ModeTemp: unit = UDeg;
        ModeMaLo, ModeMaLo2: unit = UMa;
        ModeAmpHi, ModeAmpHi2: unit = UA;
        default: unit = UV;
      endcase
    end

    // Digits through the segment table
    bad = 1'b0; has_l = 1'b0; zero = 1'b1; alpha = 3'd0; n = 14'd0;
    dot = 2'd0; dot_any = 1'b0;
    for (int i = 0; i < 4; i++) begin
      seg = (frm.body[i] & 8'hF0) | (frm.body[i+1] & 8'h0F);
      if (i < 3 && (seg & DotBit) != 8'h00) begin
        dot = 2'(i);
        dot_any = 1'b1;
      end
      code = seg_decode(seg & SegMask);
      if (code[4]) bad = 1'b1;
      ch[i] = code[3:0];
      if (code[3:0] > 4'd9) begin
        alpha = alpha + 3'd1;
        if (code[3:0] == ChL) has_l = 1'b1;
      end else begin
        if (code[3:0] != 4'd0) zero = 1'b0;
        n = 14'(n * 14'd10 + 14'(code[3:0]));
      end
    end

    isres = (unit == UOhm) || (unit == UKohm) || (unit == UMohm);
    iscur = (unit == UA) || (unit == UMa) || (unit == UUa);
    onemin = (md == ModeOhm) || (md == ModeOhmVolt) || (md == ModeCont) || isres;
    neg = f2[0];
    knd = KindNum; fp = 3'd0; sc = 3'd0; imp = 3'd0;
    if (alpha != 3'd0) begin
      if (has_l && dot_any) knd = KindOpen;
      else if (has_l && alpha == 3'd1) begin
        n = 14'd0; fp = 3'd1; sc = 3'd1; neg = 1'b0;
      end else knd = KindText;
    end else begin
      if (iscur) imp = 3'd4;
      else if (isres) imp = 3'd1;
      else if (md == ModeVoltImp && unit == UV) imp = 3'd1;
      if (imp != 3'd0 && hic && ch[0] != 4'd0) imp = 3'd2;
      if (!dot_any && imp != 3'd0) begin
        fp = imp; sc = imp;
      end else if (zero && !dot_any) begin
        neg = 1'b0;
        if (md == ModeTemp) fp = 3'd0;
        else if (onemin) begin fp = 3'd1; sc = 3'd1; end
        else if (md == ModeAuto) begin
          knd = KindText; ch = {ChO, ChT, ChU, ChA};
        end else if (md == ModeBare) begin
          knd = KindText; ch = {ChE, ChU, 4'd1, ChL};
        end else if (md == ModeMaLo2) fp = 3'd0;
        else begin fp = 3'd3; sc = 3'd3; end
      end else begin
        if (zero) neg = 1'b0;
        if (dot_any) begin fp = 3'd4 - 3'(dot); sc = fp; end
        else if (onemin) fp = 3'd1;
      end
    end

    if (knd == KindNum) begin
      if (hic) unit = UA;
      else if (loc) unit = UMa;
    end
    if (md == ModeOhm && !((unit == UOhm) || (unit == UKohm) || (unit == UMohm))) unit = UOhm;
    else if (md == ModeOhmVolt && !((unit == UV) || (unit == UMv)) &&
             !((unit == UOhm) || (unit == UKohm) || (unit == UMohm))) unit = UV;

    if (md == ModeAuto || knd == KindOpen) ok = 1'b1;
    else begin
      case (md)
        ModeVolt, ModeVoltImp: ok = (unit == UV) || (unit == UMv);
        ModeCap: ok = (unit >= UF) && (unit <= UMf);
        ModeBare: ok = (unit == UNone) || (knd == KindText && ch[0] == ChL &&
                       ch[1] == 4'd1 && ch[2] == ChU && ch[3] == ChE);
        ModeTemp: ok = (unit == UDeg);
        ModeAmpHi, ModeAmpHi2: ok = (unit == UA);
        ModeMaLo, ModeMaLo2: ok = (unit == UMa);
        default: ok = 1'b1;
      endcase
    end
    if (bad || (md == ModeTemp && has_l)) ok = 1'b0;
  end

  // Stage 2: scale, sign, compare with held reading, output register
  logic [23:0] mag;
  logic [26:0] rnd;
  reading_t    fin;
  reading_t    last_reading;
  logic        reading_held;

  always_comb begin
    // Divide by ten with rounding by reciprocal multiply: (n + 5) * 6554 / 65536
    rnd = 27'(({13'd0, s1_n} + 27'd5) * 27'd6554);
    case (s1_sc)
      3'd0: mag = 24'(s1_n) * 24'd1000;
      3'd1: mag = 24'(s1_n) * 24'd100;
      3'd2: mag = 24'(s1_n) * 24'd10;
      3'd3: mag = 24'(s1_n);
      default: mag = {13'd0, rnd[26:16]};
    endcase
    fin = s1_r;
    if (s1_num) begin
      fin.value_milli = s1_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end else begin
      fin.value_milli = 25'sd0;
      fin.frac_places = 3'd0;
    end
    if (!s1_ok) fin = '{kind: KindReject, default: '0};
  end

  assign s2_go = s1_valid && (!out_valid || !out_stall);
  assign s1_go = frm_valid && (!s1_valid || s2_go);
  assign frm_take = s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go) s1_valid <= 1'b1;
      else if (s2_go) s1_valid <= 1'b0;
      if (s2_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
  assign s2_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_ok <= ok;
      s1_n <= n;
      s1_sc <= sc;
      s1_neg <= neg;
      s1_num <= (knd == KindNum);
      s1_r.kind <= knd;
      s1_r.unit_code <= unit;
      s1_r.value_milli <= 25'sd0;
      s1_r.frac_places <= fp;
      s1_r.chars <= ch;
    end
  end

  // Hold last reading and raise changed on a difference or when no reading is held
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      reading_held <= 1'b0;
      if (rst) last_reading <= '0;
    end else if (s2_go && s2_valid && s1_ok) begin
      reading_held <= 1'b1;
      last_reading <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      kind <= fin.kind;
      unit_code <= fin.unit_code;
      value_milli <= fin.value_milli;
      frac_places <= fin.frac_places;
      char_first <= fin.chars[0];
      char_second <= fin.chars[1];
      char_third <= fin.chars[2];
      char_fourth <= fin.chars[3];
      changed <= s1_ok && (!reading_held || fin != last_reading);
    end
  end
endmodule
